// ----- rtl/core/mbtf_pkg.sv -----
// mbtf_pkg: shared constants, codes, types and the direction filter for the box track filter
`timescale 1ns / 1ps
package mbtf_pkg;

   localparam int COORD_BITS_DEF    = 12;
   localparam int ALARM_HOLD_FRAMES = 40;
   localparam int HOLD_BITS         = 6;
   localparam int SIZE_BITS         = 13;
   localparam int OFS_BITS          = 13;
   localparam int RATIO_BITS        = 9;
   localparam int WH_BITS           = 2 * SIZE_BITS;
   localparam int LIMIT_BITS        = RATIO_BITS + WH_BITS;
   localparam int CSR_DATA_BITS     = 13;
   localparam int CSR_INDEX_BITS    = 2;

   // size / 6 as (size * 10923) >> 16, exact for 13-bit sizes
   localparam int SIXTH_MUL      = 10923;
   localparam int SIXTH_MUL_BITS = 14;
   localparam int SIXTH_SHIFT    = 16;
   localparam int SIXTH_BITS     = SIZE_BITS - 2;

   localparam logic [SIZE_BITS-1:0]  WIDTH_RESET     = SIZE_BITS'(1920);
   localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET    = SIZE_BITS'(1080);
   localparam logic                  BIG_EN_RESET    = 1'b1;
   localparam logic [RATIO_BITS-1:0] BIG_RATIO_RESET = RATIO_BITS'(154);

   localparam logic [1:0] ACT_BLOCKED = 2'd0;
   localparam logic [1:0] ACT_START   = 2'd1;
   localparam logic [1:0] ACT_BOX     = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH     = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIG_EN    = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIG_RATIO = CSR_INDEX_BITS'(3);

   typedef enum logic [2:0] {
      ST_TRACKED = 3'd0,
      ST_BLOCKED = 3'd1,
      ST_SKIPPED = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_BAD     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_OPEN,
      MODE_ABORT
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_CMP,
      S_CTR,
      S_FLT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       clear_best;
      logic       cmp;
      logic       ctr;
      logic       flt;
      logic       emit;
      status_type status;
      logic       alarm;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       frame_empty;
      logic       last_box;
      logic       big;
      logic       max_pos;
      logic       out_free;
   } sts_type;

   typedef struct packed {
      logic                       turn;
      logic signed [OFS_BITS-1:0] rec;
   } dir_type;

   function automatic dir_type dir_filter(input logic [SIXTH_BITS-1:0] sixth,
                                          input logic signed [OFS_BITS-1:0] pos,
                                          input logic signed [OFS_BITS-1:0] rec);
      dir_type             res;
      logic [OFS_BITS-1:0] mag;
      logic [OFS_BITS-1:0] rmag;
      mag  = pos[OFS_BITS-1] ? OFS_BITS'(-pos) : OFS_BITS'(pos);
      rmag = rec[OFS_BITS-1] ? OFS_BITS'(-rec) : OFS_BITS'(rec);
      res.turn = 1'b0;
      res.rec  = pos;
      if (mag < {{(OFS_BITS-SIXTH_BITS){1'b0}}, sixth}) begin
         res.rec = '0;
      end else if ((rec != '0) && (rec[OFS_BITS-1] == pos[OFS_BITS-1]) && (mag >= rmag)) begin
         res.rec  = '0;
         res.turn = 1'b1;
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/mbtf_datapath.sv -----
// mbtf_datapath: config registers, box capture, area and limit multipliers, centre and output register
`timescale 1ns / 1ps
module mbtf_datapath
   import mbtf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic [1:0]                    req_action,
   input  logic                          req_frame_empty,
   input  logic [COORD_BITS-1:0]         req_box_left,
   input  logic [COORD_BITS-1:0]         req_box_top,
   input  logic [COORD_BITS-1:0]         req_box_right,
   input  logic [COORD_BITS-1:0]         req_box_bottom,
   input  logic                          req_last_box,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_alarm_report,
   output logic                          rsp_turn_x,
   output logic                          rsp_turn_y,
   output logic signed [OFS_BITS-1:0]    rsp_offset_x,
   output logic signed [OFS_BITS-1:0]    rsp_offset_y,
   output logic [COORD_BITS-1:0]         rsp_best_left,
   output logic [COORD_BITS-1:0]         rsp_best_top,
   output logic [COORD_BITS-1:0]         rsp_best_right,
   output logic [COORD_BITS-1:0]         rsp_best_bottom
);

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int AREA_BITS = 2 * SPAN_BITS;
   localparam int CMP_BITS  = (AREA_BITS + 8 > LIMIT_BITS) ? AREA_BITS + 8 : LIMIT_BITS;
   localparam int CTR_BITS  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
   localparam int PROD_BITS = SIZE_BITS + SIXTH_MUL_BITS;

   localparam logic signed [CTR_BITS-1:0] CTR_HI = CTR_BITS'((1 << (OFS_BITS - 1)) - 1);
   localparam logic signed [CTR_BITS-1:0] CTR_LO = -CTR_HI - CTR_BITS'(1);

   function automatic logic signed [OFS_BITS-1:0] sat_ofs(input logic signed [CTR_BITS-1:0] v);
      logic signed [OFS_BITS-1:0] r;
      if (v > CTR_HI) begin
         r = CTR_HI[OFS_BITS-1:0];
      end else if (v < CTR_LO) begin
         r = CTR_LO[OFS_BITS-1:0];
      end else begin
         r = v[OFS_BITS-1:0];
      end
      return r;
   endfunction

   logic [SIZE_BITS-1:0]         width_ff;
   logic [SIZE_BITS-1:0]         height_ff;
   logic                         big_en_ff;
   logic [RATIO_BITS-1:0]        ratio_ff;

   logic [1:0]                   action_ff;
   logic                         empty_ff;
   logic                         last_ff;
   logic [COORD_BITS-1:0]        left_ff;
   logic [COORD_BITS-1:0]        top_ff;
   logic [COORD_BITS-1:0]        right_ff;
   logic [COORD_BITS-1:0]        bottom_ff;

   logic signed [SPAN_BITS-1:0]  dx_ff;
   logic signed [SPAN_BITS-1:0]  dy_ff;
   logic [WH_BITS-1:0]           wh_ff;
   logic signed [AREA_BITS-1:0]  area_ff;
   logic [LIMIT_BITS-1:0]        limit_ff;
   logic [SIXTH_BITS-1:0]        wsix_ff;
   logic [SIXTH_BITS-1:0]        hsix_ff;
   logic [PROD_BITS-1:0]         wprod;
   logic [PROD_BITS-1:0]         hprod;

   logic signed [AREA_BITS-1:0]  max_area_ff;
   logic [COORD_BITS-1:0]        best_left_ff;
   logic [COORD_BITS-1:0]        best_top_ff;
   logic [COORD_BITS-1:0]        best_right_ff;
   logic [COORD_BITS-1:0]        best_bottom_ff;
   logic                         winner;

   logic signed [SPAN_BITS-1:0]  spx;
   logic signed [SPAN_BITS-1:0]  spy;
   logic signed [SPAN_BITS-1:0]  rndx;
   logic signed [SPAN_BITS-1:0]  rndy;
   logic signed [SPAN_BITS-1:0]  halfx;
   logic signed [SPAN_BITS-1:0]  halfy;
   logic signed [CTR_BITS-1:0]   sumx;
   logic signed [CTR_BITS-1:0]   sumy;
   logic signed [OFS_BITS-1:0]   cx_ff;
   logic signed [OFS_BITS-1:0]   cy_ff;

   dir_type                      dirx;
   dir_type                      diry;
   logic signed [OFS_BITS-1:0]   rec_x_ff;
   logic signed [OFS_BITS-1:0]   rec_y_ff;
   logic                         turn_x_ff;
   logic                         turn_y_ff;

   logic                         rsp_valid_ff;
   logic                         tracked;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         big_en_ff <= BIG_EN_RESET;
         ratio_ff  <= BIG_RATIO_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:     width_ff  <= csr_write_data[SIZE_BITS-1:0];
            CSR_HEIGHT:    height_ff <= csr_write_data[SIZE_BITS-1:0];
            CSR_BIG_EN:    big_en_ff <= csr_write_data[0];
            CSR_BIG_RATIO: ratio_ff  <= csr_write_data[RATIO_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         empty_ff  <= req_frame_empty;
         last_ff   <= req_last_box;
         left_ff   <= req_box_left;
         top_ff    <= req_box_top;
         right_ff  <= req_box_right;
         bottom_ff <= req_box_bottom;
      end
   end

   assign wprod = PROD_BITS'(width_ff) * PROD_BITS'(SIXTH_MUL);
   assign hprod = PROD_BITS'(height_ff) * PROD_BITS'(SIXTH_MUL);

   // spans, then area and limit products
   always_ff @(posedge clock) begin
      dx_ff    <= $signed({1'b0, right_ff}) - $signed({1'b0, left_ff});
      dy_ff    <= $signed({1'b0, bottom_ff}) - $signed({1'b0, top_ff});
      wh_ff    <= WH_BITS'(width_ff) * WH_BITS'(height_ff);
      area_ff  <= AREA_BITS'(dx_ff) * AREA_BITS'(dy_ff);
      limit_ff <= LIMIT_BITS'(wh_ff) * LIMIT_BITS'(ratio_ff);
      wsix_ff  <= wprod[SIXTH_SHIFT +: SIXTH_BITS];
      hsix_ff  <= hprod[SIXTH_SHIFT +: SIXTH_BITS];
   end

   assign winner = area_ff > max_area_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_best) begin
         max_area_ff    <= '0;
         best_left_ff   <= '0;
         best_top_ff    <= '0;
         best_right_ff  <= '0;
         best_bottom_ff <= '0;
      end else if (cmd.cmp && winner) begin
         max_area_ff    <= area_ff;
         best_left_ff   <= left_ff;
         best_top_ff    <= top_ff;
         best_right_ff  <= right_ff;
         best_bottom_ff <= bottom_ff;
      end
   end

   // centre of the chosen box relative to the image centre
   always_comb begin
      spx   = $signed({1'b0, best_right_ff}) - $signed({1'b0, best_left_ff});
      spy   = $signed({1'b0, best_bottom_ff}) - $signed({1'b0, best_top_ff});
      rndx  = $signed({{(SPAN_BITS-1){1'b0}}, spx[SPAN_BITS-1]});
      rndy  = $signed({{(SPAN_BITS-1){1'b0}}, spy[SPAN_BITS-1]});
      halfx = (spx + rndx) >>> 1;
      halfy = (spy + rndy) >>> 1;
      sumx  = CTR_BITS'(halfx) + $signed(CTR_BITS'({1'b0, best_left_ff}))
              - $signed(CTR_BITS'({1'b0, width_ff[SIZE_BITS-1:1]}));
      sumy  = CTR_BITS'(halfy) + $signed(CTR_BITS'({1'b0, best_top_ff}))
              - $signed(CTR_BITS'({1'b0, height_ff[SIZE_BITS-1:1]}));
   end

   always_ff @(posedge clock) begin
      if (cmd.ctr) begin
         cx_ff <= sat_ofs(sumx);
         cy_ff <= sat_ofs(sumy);
      end
   end

   // direction filter per axis
   assign dirx = dir_filter(wsix_ff, cx_ff, rec_x_ff);
   assign diry = dir_filter(hsix_ff, cy_ff, rec_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_x_ff <= '0;
         rec_y_ff <= '0;
      end else if (cmd.flt) begin
         rec_x_ff <= dirx.rec;
         rec_y_ff <= diry.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flt) begin
         turn_x_ff <= dirx.turn;
         turn_y_ff <= diry.turn;
      end
   end

   // output register
   assign tracked = (cmd.status == ST_TRACKED);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status       <= cmd.status;
         rsp_alarm_report <= tracked & cmd.alarm;
         rsp_turn_x       <= tracked & turn_x_ff;
         rsp_turn_y       <= tracked & turn_y_ff;
         rsp_offset_x     <= tracked ? cx_ff : '0;
         rsp_offset_y     <= tracked ? cy_ff : '0;
         rsp_best_left    <= tracked ? best_left_ff : '0;
         rsp_best_top     <= tracked ? best_top_ff : '0;
         rsp_best_right   <= tracked ? best_right_ff : '0;
         rsp_best_bottom  <= tracked ? best_bottom_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.action      = action_ff;
      sts.frame_empty = empty_ff;
      sts.last_box    = last_ff;
      sts.big         = big_en_ff && !area_ff[AREA_BITS-1] && (area_ff != '0) &&
                        (CMP_BITS'({area_ff, 8'b0}) > CMP_BITS'(limit_ff));
      sts.max_pos     = max_area_ff > '0;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("response raised without an emit command");

endmodule

// ----- rtl/core/mbtf_ctrl.sv -----
// mbtf_ctrl: request sequencer holding frame mode, track skip and alarm hold
`timescale 1ns / 1ps
module mbtf_ctrl
   import mbtf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type              state_ff;
   state_type              state_in;
   mode_type               mode_ff;
   mode_type               mode_in;
   logic                   skip_ff;
   logic                   skip_in;
   logic [HOLD_BITS-1:0]   hold_ff;
   logic [HOLD_BITS-1:0]   hold_in;
   status_type             status_ff;
   status_type             status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= MODE_IDLE;
         skip_ff   <= 1'b0;
         hold_ff   <= '0;
         status_ff <= ST_TRACKED;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         skip_ff   <= skip_in;
         hold_ff   <= hold_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      skip_in    = skip_ff;
      hold_in    = hold_ff;
      status_in  = status_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.status = status_ff;
      cmd.alarm  = (hold_ff == '0);
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (sts.action)
               ACT_BLOCKED: begin
                  skip_in   = 1'b1;
                  hold_in   = HOLD_BITS'(ALARM_HOLD_FRAMES);
                  mode_in   = MODE_IDLE;
                  status_in = ST_BLOCKED;
                  state_in  = S_EMIT;
               end
               ACT_START: begin
                  mode_in = MODE_IDLE;
                  if (skip_ff) begin
                     skip_in   = 1'b0;
                     status_in = ST_SKIPPED;
                     state_in  = S_EMIT;
                  end else begin
                     if (hold_ff != '0) begin
                        hold_in = hold_ff - HOLD_BITS'(1);
                     end
                     if (sts.frame_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_EMIT;
                     end else begin
                        cmd.clear_best = 1'b1;
                        mode_in        = MODE_OPEN;
                     end
                  end
               end
               ACT_BOX: begin
                  case (mode_ff)
                     MODE_OPEN: state_in = S_MUL;
                     MODE_ABORT: begin
                        if (sts.last_box) begin
                           mode_in   = MODE_IDLE;
                           status_in = ST_BAD;
                           state_in  = S_EMIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         S_MUL: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_IDLE;
            if (sts.big) begin
               if (sts.last_box) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_BAD;
                  state_in  = S_EMIT;
               end else begin
                  mode_in = MODE_ABORT;
               end
            end else if (sts.last_box) begin
               mode_in  = MODE_IDLE;
               state_in = S_CTR;
            end
         end
         S_CTR: begin
            if (sts.max_pos) begin
               cmd.ctr  = 1'b1;
               state_in = S_FLT;
            end else begin
               status_in = ST_BAD;
               state_in  = S_EMIT;
            end
         end
         S_FLT: begin
            cmd.flt   = 1'b1;
            status_in = ST_TRACKED;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (mode_ff == MODE_IDLE))
      else $error("track skip armed while a frame is open");

   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hold_ff <= HOLD_BITS'(ALARM_HOLD_FRAMES))
      else $error("alarm hold above its armed value");

   a_open_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_best |=> (mode_ff == MODE_OPEN))
      else $error("best box cleared without opening a frame");

endmodule

// ----- rtl/core/motion_box_track_filter.sv -----
// motion_box_track_filter: top level joining the sequencer and the datapath
// blocked, skipped, empty-frame and aborted-frame results go from decode to emit; a last box
//    runs multiply, compare, centre and filter when tracked, ends after centre when no box won
//    and after compare when too large; emit can stall; a new request waits for idle again,
//    after emit for answers, decode for silent starts and ignored boxes, compare for other boxes
// reset: synchronous; config registers take defaults, skip, hold and direction records clear
`timescale 1ns / 1ps
module motion_box_track_filter
   import mbtf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic                          req_frame_empty,
   input  logic [COORD_BITS-1:0]         req_box_left,
   input  logic [COORD_BITS-1:0]         req_box_top,
   input  logic [COORD_BITS-1:0]         req_box_right,
   input  logic [COORD_BITS-1:0]         req_box_bottom,
   input  logic                          req_last_box,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_alarm_report,
   output logic                          rsp_turn_x,
   output logic                          rsp_turn_y,
   output logic signed [OFS_BITS-1:0]    rsp_offset_x,
   output logic signed [OFS_BITS-1:0]    rsp_offset_y,
   output logic [COORD_BITS-1:0]         rsp_best_left,
   output logic [COORD_BITS-1:0]         rsp_best_top,
   output logic [COORD_BITS-1:0]         rsp_best_right,
   output logic [COORD_BITS-1:0]         rsp_best_bottom
);

   cmd_type cmd;
   sts_type sts;

   mbtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mbtf_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_action       (req_action),
      .req_frame_empty  (req_frame_empty),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_right    (req_box_right),
      .req_box_bottom   (req_box_bottom),
      .req_last_box     (req_last_box),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_alarm_report (rsp_alarm_report),
      .rsp_turn_x       (rsp_turn_x),
      .rsp_turn_y       (rsp_turn_y),
      .rsp_offset_x     (rsp_offset_x),
      .rsp_offset_y     (rsp_offset_y),
      .rsp_best_left    (rsp_best_left),
      .rsp_best_top     (rsp_best_top),
      .rsp_best_right   (rsp_best_right),
      .rsp_best_bottom  (rsp_best_bottom)
   );

endmodule
